// ===== rtl/button_gesture_classifier_top_assert.svh =====
// ----------------------------------------------------------------------------
// Button gesture classifier assertion macros
// Shared concurrent assertion forms used by the classifier RTL.
// ----------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_CLASSIFIER_TOP_ASSERT_SVH
`define BUTTON_GESTURE_CLASSIFIER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BGC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bgc check failed");

// Next-cycle implication, checked outside reset.
`define BGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bgc check failed");

`endif

// ===== rtl/bgc_pkg.sv =====
// ----------------------------------------------------------------------------
// Button gesture classifier package
// Shared types and constants for the classifier datapath.
// ----------------------------------------------------------------------------
package bgc_pkg;

    localparam int TIME_W   = 32;
    localparam int CNT_W    = 32;
    localparam int CFG_W    = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int PEND_W   = 2;

    localparam logic [PEND_W-1:0] TRIPLE_COUNT = 2'd3;
    localparam logic [PEND_W-1:0] DOUBLE_COUNT = 2'd2;
    localparam logic [PEND_W-1:0] SINGLE_COUNT = 2'd1;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd30;
    localparam logic [CFG_W-1:0] LONG_RST     = 16'd1000;
    localparam logic [CFG_W-1:0] GAP_RST      = 16'd400;

    localparam logic LEVEL_PRESSED  = 1'b0;
    localparam logic LEVEL_RELEASED = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_LONG     = 2'd1,
        CFG_GAP      = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] multi_gap_ms;
    } t_cfg;

    typedef struct packed {
        logic              raw_level;
        logic [TIME_W-1:0] now_ms;
        logic              clear_counts;
        logic              take_triple;
    } t_item;

    typedef struct packed {
        logic              debounced_level;
        logic              press_event;
        logic              long_press_event;
        logic              single_event;
        logic              double_event;
        logic              triple_event;
        logic [PEND_W-1:0] pending_presses;
        logic [CNT_W-1:0]  press_total;
        logic [CNT_W-1:0]  long_press_total;
        logic [CNT_W-1:0]  double_press_total;
        logic [CNT_W-1:0]  triple_press_total;
        logic              triple_taken;
    } t_result;

endpackage

// ===== rtl/bgc_cfg.sv =====
// ----------------------------------------------------------------------------
// Button gesture classifier configuration registers
// Holds the debounce, long-press and sequence-gap times.
// ----------------------------------------------------------------------------
module bgc_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [bgc_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [bgc_pkg::CFG_W-1:0]        i_cfg_wdata,
    output bgc_pkg::t_cfg                    o_cfg
);

    bgc_pkg::t_cfg r_cfg;
    bgc_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (bgc_pkg::t_cfg_idx'(i_cfg_addr))
                bgc_pkg::CFG_DEBOUNCE: n_cfg.debounce_ms   = i_cfg_wdata;
                bgc_pkg::CFG_LONG:     n_cfg.long_press_ms = i_cfg_wdata;
                bgc_pkg::CFG_GAP:      n_cfg.multi_gap_ms  = i_cfg_wdata;
                default:               n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms   <= bgc_pkg::DEBOUNCE_RST;
            r_cfg.long_press_ms <= bgc_pkg::LONG_RST;
            r_cfg.multi_gap_ms  <= bgc_pkg::GAP_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/bgc_engine.sv =====
// ----------------------------------------------------------------------------
// Button gesture classifier engine
// Gesture state and the single-pass step logic for one sample word.
// ----------------------------------------------------------------------------
module bgc_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bgc_pkg::t_cfg     i_cfg,
    input  bgc_pkg::t_item    i_item,
    input  logic              i_commit,
    output bgc_pkg::t_result  o_result
);

    logic                               r_last_raw, n_last_raw;
    logic                               r_stable, n_stable;
    logic [bgc_pkg::TIME_W-1:0]         r_raw_chg_time, n_raw_chg_time;
    logic [bgc_pkg::TIME_W-1:0]         r_pressed_time, n_pressed_time;
    logic                               r_long_seen, n_long_seen;
    logic [bgc_pkg::PEND_W-1:0]         r_pending, n_pending;
    logic [bgc_pkg::TIME_W-1:0]         r_rel_time, n_rel_time;
    logic [bgc_pkg::CNT_W-1:0]          r_press_cnt, n_press_cnt;
    logic [bgc_pkg::CNT_W-1:0]          r_long_cnt, n_long_cnt;
    logic [bgc_pkg::CNT_W-1:0]          r_double_cnt, n_double_cnt;
    logic [bgc_pkg::CNT_W-1:0]          r_triple_cnt, n_triple_cnt;
    logic                               r_sticky, n_sticky;

    logic [bgc_pkg::TIME_W-1:0] deb_diff;
    logic [bgc_pkg::TIME_W-1:0] hold_diff;
    logic [bgc_pkg::TIME_W-1:0] gap_diff;
    logic [bgc_pkg::TIME_W-1:0] deb_lim;
    logic [bgc_pkg::TIME_W-1:0] long_lim;
    logic [bgc_pkg::TIME_W-1:0] gap_lim;
    logic                       raw_chg;
    logic                       deb_ok;
    logic                       deb_fire;
    logic                       rel_now;
    logic                       hold_ok;
    logic                       gap_ok;
    bgc_pkg::t_result           res;

    // The three time differences run in parallel against the old state;
    // a timestamp that is set in this step gives a difference of zero.
    assign deb_diff  = i_item.now_ms - r_raw_chg_time;
    assign hold_diff = i_item.now_ms - r_pressed_time;
    assign gap_diff  = i_item.now_ms - r_rel_time;
    assign deb_lim   = {{(bgc_pkg::TIME_W-bgc_pkg::CFG_W){1'b0}}, i_cfg.debounce_ms};
    assign long_lim  = {{(bgc_pkg::TIME_W-bgc_pkg::CFG_W){1'b0}}, i_cfg.long_press_ms};
    assign gap_lim   = {{(bgc_pkg::TIME_W-bgc_pkg::CFG_W){1'b0}}, i_cfg.multi_gap_ms};

    assign raw_chg  = i_item.raw_level != r_last_raw;
    assign deb_ok   = raw_chg ? (i_cfg.debounce_ms == '0) : (deb_diff >= deb_lim);
    assign deb_fire = deb_ok && (i_item.raw_level != r_stable);

    always_comb begin
        n_last_raw     = i_item.raw_level;
        n_raw_chg_time = raw_chg ? i_item.now_ms : r_raw_chg_time;
        n_stable       = r_stable;
        n_pressed_time = r_pressed_time;
        n_long_seen    = r_long_seen;
        n_pending      = r_pending;
        n_rel_time     = r_rel_time;
        n_press_cnt    = r_press_cnt;
        n_long_cnt     = r_long_cnt;
        n_double_cnt   = r_double_cnt;
        n_triple_cnt   = r_triple_cnt;
        n_sticky       = r_sticky;
        rel_now        = 1'b0;
        hold_ok        = 1'b0;
        gap_ok         = 1'b0;
        res            = '0;

        // Clear diagnostics ahead of the step.
        if (i_item.clear_counts) begin
            n_press_cnt  = '0;
            n_long_cnt   = '0;
            n_double_cnt = '0;
            n_triple_cnt = '0;
            n_sticky     = 1'b0;
            n_pending    = '0;
            n_rel_time   = '0;
            n_long_seen  = 1'b0;
        end

        if (deb_fire) begin
            n_stable = i_item.raw_level;
            if (i_item.raw_level == bgc_pkg::LEVEL_PRESSED) begin
                n_press_cnt     = n_press_cnt + bgc_pkg::CNT_W'(1);
                n_pressed_time  = i_item.now_ms;
                n_long_seen     = 1'b0;
                res.press_event = 1'b1;
            end else if (!n_long_seen) begin
                n_pending  = n_pending + bgc_pkg::PEND_W'(1);
                n_rel_time = i_item.now_ms;
                rel_now    = 1'b1;
                if (n_pending >= bgc_pkg::TRIPLE_COUNT) begin
                    n_triple_cnt     = n_triple_cnt + bgc_pkg::CNT_W'(1);
                    n_sticky         = 1'b1;
                    res.triple_event = 1'b1;
                    n_pending        = '0;
                end
            end else begin
                n_pending = '0;
            end
        end

        hold_ok = res.press_event ? (i_cfg.long_press_ms == '0) : (hold_diff >= long_lim);
        if (n_stable == bgc_pkg::LEVEL_PRESSED && !n_long_seen && hold_ok) begin
            n_long_seen          = 1'b1;
            n_long_cnt           = n_long_cnt + bgc_pkg::CNT_W'(1);
            n_pending            = '0;
            res.long_press_event = 1'b1;
        end

        // Release time is now, zero after a clear, or the stored mark.
        if (rel_now) begin
            gap_ok = i_cfg.multi_gap_ms == '0;
        end else if (i_item.clear_counts) begin
            gap_ok = i_item.now_ms >= gap_lim;
        end else begin
            gap_ok = gap_diff >= gap_lim;
        end
        if (n_stable == bgc_pkg::LEVEL_RELEASED && n_pending != '0 && gap_ok) begin
            if (n_pending == bgc_pkg::DOUBLE_COUNT) begin
                n_double_cnt     = n_double_cnt + bgc_pkg::CNT_W'(1);
                res.double_event = 1'b1;
            end else if (n_pending == bgc_pkg::SINGLE_COUNT) begin
                res.single_event = 1'b1;
            end
            n_pending = '0;
        end

        if (i_item.take_triple) begin
            res.triple_taken = n_sticky;
            n_sticky         = 1'b0;
        end

        res.debounced_level    = n_stable;
        res.pending_presses    = n_pending;
        res.press_total        = n_press_cnt;
        res.long_press_total   = n_long_cnt;
        res.double_press_total = n_double_cnt;
        res.triple_press_total = n_triple_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw     <= bgc_pkg::LEVEL_RELEASED;
            r_stable       <= bgc_pkg::LEVEL_RELEASED;
            r_raw_chg_time <= '0;
            r_pressed_time <= '0;
            r_long_seen    <= 1'b0;
            r_pending      <= '0;
            r_rel_time     <= '0;
            r_press_cnt    <= '0;
            r_long_cnt     <= '0;
            r_double_cnt   <= '0;
            r_triple_cnt   <= '0;
            r_sticky       <= 1'b0;
        end else if (i_commit) begin
            r_last_raw     <= n_last_raw;
            r_stable       <= n_stable;
            r_raw_chg_time <= n_raw_chg_time;
            r_pressed_time <= n_pressed_time;
            r_long_seen    <= n_long_seen;
            r_pending      <= n_pending;
            r_rel_time     <= n_rel_time;
            r_press_cnt    <= n_press_cnt;
            r_long_cnt     <= n_long_cnt;
            r_double_cnt   <= n_double_cnt;
            r_triple_cnt   <= n_triple_cnt;
            r_sticky       <= n_sticky;
        end
    end

    assign o_result = res;

endmodule

// ===== rtl/button_gesture_classifier_top.sv =====
// ----------------------------------------------------------------------------
// Button gesture classifier top level
// Debounce, press, long-press and multi-press detection for one button.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one pin sample word:
//   raw level, millisecond timestamp, clear and take-triple requests.
//   Output channel (o_out_valid / i_out_ready) returns one result word per
//   sample: debounced level, event flags, pending count, totals, taken flag.
//   Configuration is a plain write port (i_cfg_wr_en, i_cfg_addr,
//   i_cfg_wdata); write it only while no sample is in flight.
//   Path: an accepted sample waits in the input register, then passes
//   through one step of logic into the result register.
//   Throughput: one sample per cycle unless stalled; the step logic holds
//   three 32-bit subtract/compare paths and four counter increments.
//   Reset: times return to 30/1000/400 ms, the button reads released, all
//   counters and pending state clear, both registers empty.
//   Stall: with i_out_ready low the result word holds, the input register
//   keeps one more sample, and o_in_ready falls until the output drains.
// ----------------------------------------------------------------------------
`include "button_gesture_classifier_top_assert.svh"

module button_gesture_classifier_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [bgc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [bgc_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_raw_level,
    input  logic [bgc_pkg::TIME_W-1:0]      i_now_ms,
    input  logic                            i_clear_counts,
    input  logic                            i_take_triple,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_debounced_level,
    output logic                            o_press_event,
    output logic                            o_long_press_event,
    output logic                            o_single_event,
    output logic                            o_double_event,
    output logic                            o_triple_event,
    output logic [bgc_pkg::PEND_W-1:0]      o_pending_presses,
    output logic [bgc_pkg::CNT_W-1:0]       o_press_total,
    output logic [bgc_pkg::CNT_W-1:0]       o_long_press_total,
    output logic [bgc_pkg::CNT_W-1:0]       o_double_press_total,
    output logic [bgc_pkg::CNT_W-1:0]       o_triple_press_total,
    output logic                            o_triple_taken
);

    bgc_pkg::t_cfg    cfg;
    bgc_pkg::t_result step_res;

    logic             r_in_valid;
    bgc_pkg::t_item   r_in;
    logic             r_out_valid;
    bgc_pkg::t_result r_out;
    logic             stage_move;
    logic             in_fire;

    bgc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    bgc_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_item   (r_in),
        .i_commit (stage_move),
        .o_result (step_res)
    );

    // Advance the held sample whenever the result register is free or drains.
    assign stage_move = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || stage_move;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in.raw_level    <= i_raw_level;
            r_in.now_ms       <= i_now_ms;
            r_in.clear_counts <= i_clear_counts;
            r_in.take_triple  <= i_take_triple;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stage_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_move) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_debounced_level    = r_out.debounced_level;
    assign o_press_event        = r_out.press_event;
    assign o_long_press_event   = r_out.long_press_event;
    assign o_single_event       = r_out.single_event;
    assign o_double_event       = r_out.double_event;
    assign o_triple_event       = r_out.triple_event;
    assign o_pending_presses    = r_out.pending_presses;
    assign o_press_total        = r_out.press_total;
    assign o_long_press_total   = r_out.long_press_total;
    assign o_double_press_total = r_out.double_press_total;
    assign o_triple_press_total = r_out.triple_press_total;
    assign o_triple_taken       = r_out.triple_taken;

    `BGC_ASSERT_NEXT(a_move_fills_out, i_clk, i_rst_n, stage_move, r_out_valid)
    `BGC_ASSERT_NOW(a_press_is_low, i_clk, i_rst_n,
        r_out_valid && r_out.press_event,
        r_out.debounced_level == bgc_pkg::LEVEL_PRESSED)
    `BGC_ASSERT_NOW(a_close_one_kind, i_clk, i_rst_n, r_out_valid,
        !(r_out.single_event && r_out.double_event) &&
        r_out.pending_presses != bgc_pkg::TRIPLE_COUNT)
    `BGC_ASSERT_NOW(a_event_clears_pend, i_clk, i_rst_n,
        stage_move && (step_res.long_press_event || step_res.triple_event),
        step_res.pending_presses == '0)

endmodule
